// ----- hw/rtl/swpd_pkg.sv -----
// Package for the sync word packet deframer.
// Holds the sync word table, status codes and shared types; no dependencies.
package swpd_pkg;

   localparam int SYNC_LENGTH_DEF = 8;
   localparam int SIZE_WIDTH_DEF  = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam logic [15:0] MAX_SIZE_RESET = 16'd4096;

   typedef enum logic [2:0] {
      ST_HUNTING  = 3'd0,
      ST_SYNC     = 3'd1,
      ST_HEADER   = 3'd2,
      ST_PAYLOAD  = 3'd3,
      ST_DONE     = 3'd4,
      ST_OVERSIZE = 3'd5,
      ST_BUSY     = 3'd6,
      ST_RELEASED = 3'd7
   } status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // sync bytes past the eighth are zero
   function automatic logic [7:0] sync_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'hF0;
         4'd1:    val = 8'h04;
         4'd2:    val = 8'h11;
         4'd3:    val = 8'h9B;
         4'd4:    val = 8'h39;
         4'd5:    val = 8'hBC;
         4'd6:    val = 8'hE4;
         4'd7:    val = 8'hD2;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/swpd_front.sv -----
// Front end of the deframer: accepts input beats and compares each byte
// against every sync byte. Depends on swpd_pkg; feeds swpd_queue.
module swpd_front #(
   parameter int SYNC_LENGTH = swpd_pkg::SYNC_LENGTH_DEF
) (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [7:0]              req_data_byte,
   input  swpd_pkg::qstat_type     qstat,
   output logic                    push,
   output logic [SYNC_LENGTH+8:0]  push_data
);
   import swpd_pkg::*;

   logic [SYNC_LENGTH-1:0] match;

   always_comb begin
      for (int i = 0; i < SYNC_LENGTH; i++) begin
         match[i] = (req_data_byte == sync_byte(4'(i)));
      end
   end

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;
   assign push_data = {match, req_action, req_data_byte};

endmodule

// ----- hw/rtl/swpd_queue.sv -----
// Short queue between the front and back of the deframer.
// Depends on swpd_pkg for the depth and status struct.
module swpd_queue #(
   parameter int WIDTH = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output swpd_pkg::qstat_type  qstat
);
   import swpd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push = push && !qstat.full;
   assign do_pop  = pop && !qstat.empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count past depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push lost");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue pop lost");

endmodule

// ----- hw/rtl/swpd_back.sv -----
// Back end of the deframer: sync hunt, header and payload state machine
// plus the result register. Depends on swpd_pkg; reads from swpd_queue.
module swpd_back #(
   parameter int SYNC_LENGTH = swpd_pkg::SYNC_LENGTH_DEF,
   parameter int SIZE_WIDTH  = swpd_pkg::SIZE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [15:0]             csr_write_data,
   input  swpd_pkg::qstat_type     qstat,
   input  logic [SYNC_LENGTH+8:0]  pop_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_payload_byte,
   output logic [15:0]             rsp_payload_index,
   output logic                    rsp_last_byte,
   output logic [7:0]              rsp_frame_type,
   output logic [15:0]             rsp_frame_size
);
   import swpd_pkg::*;

   localparam int POS_W = (SYNC_LENGTH > 1) ? $clog2(SYNC_LENGTH) : 1;
   localparam logic [POS_W:0] SYNC_DONE = (POS_W + 1)'(SYNC_LENGTH);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_WAIT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [1:0]             hdr_ff, hdr_in;
   logic [7:0]             type_ff, type_in;
   logic [SIZE_WIDTH-1:0]  size_ff, size_in;
   logic [15:0]            ppos_ff, ppos_in;
   logic [15:0]            max_size_ff;
   logic                   rsp_valid_ff;
   status_type             status_ff, status_in;
   logic [7:0]             pbyte_ff, pbyte_in;
   logic [15:0]            pindex_ff, pindex_in;
   logic                   last_ff, last_in;
   logic [7:0]             rtype_ff;
   logic [15:0]            rsize_ff, rsize_in;

   logic                   act;
   logic [7:0]             b;
   logic [SYNC_LENGTH-1:0] match;
   logic [POS_W:0]         pos_next;
   logic [15:0]            size_full, ppos_next;
   logic [SIZE_WIDTH-1:0]  size_new;
   logic                   clr;

   assign {match, act, b} = pop_data;
   assign pop = !qstat.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      type_in   = type_ff;
      size_in   = size_ff;
      ppos_in   = ppos_ff;
      status_in = ST_HUNTING;
      pbyte_in  = '0;
      pindex_in = '0;
      last_in   = 1'b0;
      clr       = 1'b0;
      pos_next  = '0;
      size_full = '0;
      size_new  = '0;
      ppos_next = '0;
      case (phase_ff)
         PH_HUNT: begin
            status_in = ST_HUNTING;
            if (!act) begin
               if (match[pos_ff]) begin
                  pos_next = {1'b0, pos_ff} + 1'b1;
               end else if (match[0]) begin
                  pos_next = (POS_W + 1)'(1);
               end
               if (pos_next == SYNC_DONE) begin
                  pos_in    = '0;
                  hdr_in    = '0;
                  phase_in  = PH_HEADER;
                  status_in = ST_SYNC;
               end else begin
                  pos_in = pos_next[POS_W-1:0];
               end
            end
         end
         PH_HEADER: begin
            status_in = ST_HEADER;
            if (!act) begin
               case (hdr_ff)
                  2'd0: begin
                     type_in = b;
                     hdr_in  = 2'd1;
                  end
                  2'd1: begin
                     size_in = SIZE_WIDTH'(b);
                     hdr_in  = 2'd2;
                  end
                  default: begin
                     size_full = {b, size_ff[7:0]};
                     size_new  = size_full[SIZE_WIDTH-1:0];
                     size_in   = size_new;
                     hdr_in    = '0;
                     ppos_in   = '0;
                     if (16'(size_new) > max_size_ff) begin
                        status_in = ST_OVERSIZE;
                        phase_in  = PH_HUNT;
                        clr       = 1'b1;
                     end else if (size_new == '0) begin
                        status_in = ST_DONE;
                        last_in   = 1'b1;
                        phase_in  = PH_WAIT;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               endcase
            end
         end
         PH_PAYLOAD: begin
            status_in = ST_PAYLOAD;
            if (!act) begin
               pbyte_in  = b;
               pindex_in = ppos_ff;
               ppos_next = ppos_ff + 1'b1;
               ppos_in   = ppos_next;
               if (ppos_next >= 16'(size_ff) || ppos_next == '0) begin
                  status_in = ST_DONE;
                  last_in   = 1'b1;
                  phase_in  = PH_WAIT;
               end
            end
         end
         default: begin
            if (act) begin
               status_in = ST_RELEASED;
               phase_in  = PH_HUNT;
               clr       = 1'b1;
            end else begin
               status_in = ST_BUSY;
            end
         end
      endcase
      rsize_in = 16'(size_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         hdr_ff       <= '0;
         type_ff      <= '0;
         size_ff      <= '0;
         ppos_ff      <= '0;
         max_size_ff  <= MAX_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_size_ff <= csr_write_data;
         end
         if (pop) begin
            phase_ff     <= phase_in;
            pos_ff       <= clr ? '0 : pos_in;
            hdr_ff       <= clr ? '0 : hdr_in;
            type_ff      <= clr ? '0 : type_in;
            size_ff      <= clr ? '0 : size_in;
            ppos_ff      <= clr ? '0 : ppos_in;
            rsp_valid_ff <= 1'b1;
            status_ff    <= status_in;
            pbyte_ff     <= pbyte_in;
            pindex_ff    <= pindex_in;
            last_ff      <= last_in;
            rtype_ff     <= type_in;
            rsize_ff     <= rsize_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_payload_index = pindex_ff;
   assign rsp_last_byte     = last_ff;
   assign rsp_frame_type    = rtype_ff;
   assign rsp_frame_size    = rsize_ff;

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> size_ff != '0)
      else $error("payload phase with zero size");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> (type_ff == '0 && size_ff == '0 && hdr_ff == '0))
      else $error("header state left over while hunting");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((status_ff == ST_DONE) == last_ff))
      else $error("last flag disagrees with status");

endmodule

// ----- hw/rtl/sync_word_packet_deframer.sv -----
// Top level of the sync word packet deframer.
// Depends on swpd_pkg, swpd_front, swpd_queue and swpd_back.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_action,        | in
//          | req_data_byte                            |
//  rsp     | rsp_valid, rsp_stall, rsp_status, ...    | out
//  csr     | csr_write_enable, csr_write_data         | in
//
// One beat per cycle sustained while rsp_stall is low; a taken request beat
// passes through the two-entry queue, then into the result register.
// A queued beat is popped when the result register is empty or being taken.
// req_stall rises only when the queue is full. Reset is synchronous, high.
module sync_word_packet_deframer #(
   parameter int SYNC_LENGTH = swpd_pkg::SYNC_LENGTH_DEF,
   parameter int SIZE_WIDTH  = swpd_pkg::SIZE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic        rsp_last_byte,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_size
);
   import swpd_pkg::*;

   localparam int ITEM_W = SYNC_LENGTH + 9;

   qstat_type         qstat;
   logic              push, pop;
   logic [ITEM_W-1:0] push_data, pop_data;

   swpd_front #(
      .SYNC_LENGTH (SYNC_LENGTH)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .qstat         (qstat),
      .push          (push),
      .push_data     (push_data)
   );

   swpd_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   swpd_back #(
      .SYNC_LENGTH (SYNC_LENGTH),
      .SIZE_WIDTH  (SIZE_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .qstat             (qstat),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_size    (rsp_frame_size)
   );

endmodule
